// ===== hw/rtl/soeu_pkg.sv =====
package soeu_pkg;

	// operation codes
	localparam logic [2:0] CMD_RRC  = 3'd0;
	localparam logic [2:0] CMD_SWPB = 3'd1;
	localparam logic [2:0] CMD_RRA  = 3'd2;
	localparam logic [2:0] CMD_SXT  = 3'd3;
	localparam logic [2:0] CMD_PUSH = 3'd4;
	localparam logic [2:0] CMD_CALL = 3'd5;
	localparam logic [2:0] CMD_RETI = 3'd6;
	localparam logic [2:0] CMD_UNK  = 3'd7;

	// operand kinds
	localparam logic [1:0] KIND_REG   = 2'd0;
	localparam logic [1:0] KIND_MEM   = 2'd1;
	localparam logic [1:0] KIND_CONST = 2'd2;
	localparam logic [1:0] KIND_IMM   = 2'd3;

	// result destinations
	localparam logic [1:0] DEST_NONE = 2'd0;
	localparam logic [1:0] DEST_REG  = 2'd1;
	localparam logic [1:0] DEST_MEM  = 2'd2;

	// addressing modes (As)
	localparam logic [1:0] AS_REG     = 2'd0;
	localparam logic [1:0] AS_INDEX   = 2'd1;
	localparam logic [1:0] AS_INDIR   = 2'd2;
	localparam logic [1:0] AS_AUTOINC = 2'd3;

	// special register numbers
	localparam logic [3:0] REG_PC = 4'd0;
	localparam logic [3:0] REG_SR = 4'd2;
	localparam logic [3:0] REG_CG = 4'd3;

	localparam logic [15:0] HI_BYTE_MASK = 16'hFF00;
	localparam logic [15:0] LO_BYTE_MASK = 16'h00FF;
	localparam logic [15:0] ALL_ONES     = 16'hFFFF;

	localparam int IN_DATA_W  = 104;
	localparam int IN_USER_W  = 6;
	localparam int OUT_DATA_W = 104;
	localparam int OUT_USER_W = 7;

	// one input word, unpacked
	typedef struct packed {
		logic [2:0]  cmd;
		logic        byte_mode;
		logic [1:0]  addr_mode;
		logic [3:0]  src_reg;
		logic [15:0] reg_value;
		logic [15:0] ext_word;
		logic [15:0] mem_value;
		logic        carry_in;
		logic [15:0] stack_pointer;
		logic [15:0] program_counter;
		logic [15:0] stack_word;
	} soeu_in_t;

	// resolved operand, from decode to execute
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  dkind;
		logic [15:0] ea;
		logic [15:0] wb;
		logic [15:0] op;
	} soeu_opnd_t;

	// one result word
	typedef struct packed {
		logic [1:0]  operand_kind;
		logic [15:0] effective_address;
		logic [15:0] reg_writeback;
		logic [15:0] result_value;
		logic [1:0]  result_dest;
		logic [3:0]  status_flags;
		logic        flags_written;
		logic [15:0] sp_out;
		logic [15:0] pc_out;
		logic [15:0] stack_data;
		logic        stack_write;
		logic        unknown_op;
	} soeu_res_t;

endpackage

// ===== hw/rtl/soeu_operand.sv =====
module soeu_operand import soeu_pkg::*; (
	input  soeu_in_t   item,
	output soeu_opnd_t opnd
);

	logic cg;

	// constant generator: R2 with As 2/3, R3 always
	assign cg = ((item.src_reg == REG_SR) && (item.addr_mode[1] == 1'b1)) ||
		(item.src_reg == REG_CG);

	always_comb begin
		opnd.kind = KIND_REG;
		opnd.ea   = 16'h0000;
		opnd.wb   = item.reg_value;
		opnd.op   = item.reg_value;

		if (cg) begin
			opnd.kind = KIND_CONST;
			if (item.src_reg == REG_SR) begin
				opnd.op = (item.addr_mode == AS_INDIR) ? 16'd4 : 16'd8;
			end else begin
				case (item.addr_mode)
					AS_REG:   opnd.op = 16'd0;
					AS_INDEX: opnd.op = 16'd1;
					AS_INDIR: opnd.op = 16'd2;
					default:  opnd.op = ALL_ONES;
				endcase
			end
		end else if (item.addr_mode == AS_REG) begin
			opnd.kind = KIND_REG;
		end else if (item.addr_mode == AS_INDEX) begin
			// indexed, symbolic (pc relative) or absolute
			opnd.kind = KIND_MEM;
			opnd.op   = item.mem_value;
			if (item.src_reg == REG_PC)
				opnd.ea = item.program_counter + item.ext_word;
			else if (item.src_reg == REG_SR)
				opnd.ea = item.ext_word;
			else
				opnd.ea = item.reg_value + item.ext_word;
		end else if ((item.addr_mode == AS_AUTOINC) && (item.src_reg == REG_PC)) begin
			opnd.kind = KIND_IMM;
			opnd.op   = item.ext_word;
		end else begin
			// indirect, optionally autoincrement
			opnd.kind = KIND_MEM;
			opnd.ea   = item.reg_value;
			opnd.op   = item.mem_value;
			if (item.addr_mode == AS_AUTOINC)
				opnd.wb = item.reg_value + (item.byte_mode ? 16'd1 : 16'd2);
		end

		// byte op in register mode clears the upper byte first
		if ((item.addr_mode == AS_REG) && item.byte_mode) begin
			opnd.wb = item.reg_value & LO_BYTE_MASK;
			if (opnd.kind == KIND_REG)
				opnd.op = item.reg_value & LO_BYTE_MASK;
		end

		if (opnd.kind == KIND_REG)
			opnd.dkind = DEST_REG;
		else if (opnd.kind == KIND_MEM)
			opnd.dkind = DEST_MEM;
		else
			opnd.dkind = DEST_NONE;
	end

endmodule

// ===== hw/rtl/soeu_alu.sv =====
module soeu_alu import soeu_pkg::*; (
	input  soeu_in_t   item,
	input  soeu_opnd_t opnd,
	output soeu_res_t  res
);

	logic [7:0]  lo;
	logic [15:0] rv;
	logic        n;
	logic        z;
	logic        c;
	logic        fw;

	assign lo = opnd.op[7:0];

	always_comb begin
		rv = 16'h0000;
		n  = 1'b0;
		z  = 1'b0;
		c  = 1'b0;
		fw = 1'b0;
		res.result_dest = DEST_NONE;
		res.sp_out      = item.stack_pointer;
		res.pc_out      = item.program_counter;
		res.stack_data  = 16'h0000;
		res.stack_write = 1'b0;
		res.unknown_op  = 1'b0;

		case (item.cmd)
			CMD_RRC: begin
				if (item.byte_mode) begin
					c  = lo[0];
					rv = {8'h00, item.carry_in, lo[7:1]};
					n  = rv[7];
				end else begin
					c  = opnd.op[0];
					rv = {item.carry_in, opnd.op[15:1]};
					n  = rv[15];
				end
				z  = (rv == 16'h0000);
				fw = 1'b1;
				res.result_dest = opnd.dkind;
			end
			CMD_SWPB: begin
				rv = {opnd.op[7:0], opnd.op[15:8]};
				res.result_dest = opnd.dkind;
			end
			CMD_RRA: begin
				// byte form keeps bit 7 of the low byte
				if (item.byte_mode) begin
					c  = lo[0];
					rv = {8'h00, lo[7], lo[7:1]};
					n  = rv[7];
				end else begin
					c  = opnd.op[0];
					rv = {opnd.op[15], opnd.op[15:1]};
					n  = rv[15];
				end
				z  = (rv == 16'h0000);
				fw = 1'b1;
				res.result_dest = opnd.dkind;
			end
			CMD_SXT: begin
				rv = {{8{opnd.op[7]}}, opnd.op[7:0]};
				n  = rv[15];
				z  = (rv == 16'h0000);
				c  = ~z;
				fw = 1'b1;
				res.result_dest = opnd.dkind;
			end
			CMD_PUSH: begin
				res.sp_out      = item.stack_pointer - 16'd2;
				res.stack_data  = item.byte_mode ?
					((item.stack_word & HI_BYTE_MASK) | {8'h00, lo}) : opnd.op;
				res.stack_write = 1'b1;
			end
			CMD_CALL: begin
				res.sp_out      = item.stack_pointer - 16'd2;
				res.stack_data  = item.program_counter;
				res.stack_write = 1'b1;
				res.pc_out      = opnd.op;
			end
			default: begin
				res.unknown_op = 1'b1;
			end
		endcase

		res.operand_kind      = opnd.kind;
		res.effective_address = opnd.ea;
		res.reg_writeback     = opnd.wb;
		res.result_value      = rv;
		res.flags_written     = fw;
		res.status_flags      = fw ? {n, z, c, 1'b0} : 4'h0;
	end

endmodule

// ===== hw/rtl/single_operand_execute_unit.sv =====
// Single-operand instruction execute unit.
// Two register stages (input register, result register); the result word is presented
// from the result register, after the word has passed through the input register.
// Throughput: one word per cycle; while a result waits downstream a new word is taken
// only if the input register is empty. Both stages advance when the result register
// is empty or being drained.
// Reset (arst_n low, asynchronous) clears both stage valid flags; payload is not reset.
module single_operand_execute_unit import soeu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// src_reg, reg_value, ext_word, mem_value, carry_in, stack_pointer,
	// program_counter, stack_word, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd, byte_mode, addr_mode
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// effective_address, reg_writeback, result_value, status_flags, sp_out,
	// pc_out, stack_data, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// operand_kind, result_dest, flags_written, stack_write, unknown_op
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	soeu_in_t   item_in;
	soeu_in_t   item_s1;
	logic       vld_s1;
	soeu_opnd_t opnd;
	soeu_res_t  res;
	soeu_res_t  res_s2;
	logic       vld_s2;
	logic       adv;
	logic       in_acc;

	// unpack the input word
	assign item_in.cmd             = s_axis_tuser[2:0];
	assign item_in.byte_mode       = s_axis_tuser[3];
	assign item_in.addr_mode       = s_axis_tuser[5:4];
	assign item_in.src_reg         = s_axis_tdata[3:0];
	assign item_in.reg_value       = s_axis_tdata[19:4];
	assign item_in.ext_word        = s_axis_tdata[35:20];
	assign item_in.mem_value       = s_axis_tdata[51:36];
	assign item_in.carry_in        = s_axis_tdata[52];
	assign item_in.stack_pointer   = s_axis_tdata[68:53];
	assign item_in.program_counter = s_axis_tdata[84:69];
	assign item_in.stack_word      = s_axis_tdata[100:85];

	// pipeline control
	assign adv           = ~vld_s2 | m_axis_tready;
	assign s_axis_tready = ~vld_s1 | adv;
	assign in_acc        = s_axis_tvalid & s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_in;
		end
	end

	soeu_operand u_operand (
		.item (item_s1),
		.opnd (opnd)
	);

	soeu_alu u_alu (
		.item (item_s1),
		.opnd (opnd),
		.res  (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res_s2 <= res;
		end
	end

	// pack the result word
	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {4'b0000, res_s2.stack_data, res_s2.pc_out, res_s2.sp_out,
		res_s2.status_flags, res_s2.result_value, res_s2.reg_writeback,
		res_s2.effective_address};
	assign m_axis_tuser  = {res_s2.unknown_op, res_s2.stack_write, res_s2.flags_written,
		res_s2.result_dest, res_s2.operand_kind};

	// an accepted word is in the input register next cycle
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> vld_s1)
		else $error("accepted word lost before input register");

	// a word in the input register moves to the result register when it advances
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && adv) |=> vld_s2)
		else $error("word lost between stages");

	// unknown opcodes write nothing
	a_unknown_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.unknown_op) |->
		(res_s2.result_dest == DEST_NONE && !res_s2.stack_write && !res_s2.flags_written))
		else $error("unknown opcode produced a write");

	// memory destination only for memory operands
	a_dest_mem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.result_dest == DEST_MEM) |-> (res_s2.operand_kind == KIND_MEM))
		else $error("memory write for a non-memory operand");

	// flags are zero unless written
	a_flags_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !res_s2.flags_written) |-> (res_s2.status_flags == 4'h0))
		else $error("status flags set without flag update");

endmodule
